[sv/trcs_pkg.sv]
// Shared types and sizing constants for the rectangle clip and panel split block.
package trcs_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_PANELS        = 4;
    localparam int DEF_PANEL_WIDTH   = 172;
    localparam int DEF_CANVAS_HEIGHT = 320;

    // Upper ends of the parameter ranges; the job record is sized for them
    localparam int MAX_PANELS      = 16;
    localparam int MAX_PANEL_WIDTH = 1024;
    localparam int MAX_CANVAS_H    = 1024;

    // Most parts one command can give
    localparam int MAX_PARTS = 4;
    localparam int CNT_W     = $clog2(MAX_PARTS);

    // Job record field widths
    localparam int J_IDX_W = $clog2(MAX_PANELS);
    localparam int J_LOC_W = $clog2(MAX_PANEL_WIDTH);
    localparam int J_X_W   = $clog2(MAX_PANELS * MAX_PANEL_WIDTH + 1);
    localparam int J_Y_W   = $clog2(MAX_CANVAS_H);
    localparam int J_H_W   = $clog2(MAX_CANVAS_H + 1);

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Incoming fill-rectangle request
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic        [15:0] fill_colour;
    } t_req;

    // One part handed to a panel
    typedef struct packed {
        logic [1:0]  panel;
        logic [7:0]  local_x;
        logic [8:0]  out_y;
        logic [7:0]  part_width;
        logic [8:0]  part_height;
        logic [15:0] out_colour;
        logic        last_part;
    } t_part;

    // Clipped rectangle with its first panel resolved
    typedef struct packed {
        logic [J_IDX_W-1:0] idx;
        logic [J_LOC_W-1:0] loc;
        logic [J_X_W-1:0]   width;
        logic [J_Y_W-1:0]   top;
        logic [J_H_W-1:0]   height;
        logic [15:0]        colour;
    } t_job;

endpackage

[sv/trcs_front.sv]
// Front end: takes requests, rejects or clips them, finds the first panel.
module trcs_front import trcs_pkg::*; #(
    parameter int PANELS        = DEF_PANELS,
    parameter int PANEL_WIDTH   = DEF_PANEL_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    localparam logic signed [17:0] TW_S = 18'(PANELS * PANEL_WIDTH);
    localparam logic signed [17:0] TH_S = 18'(CANVAS_HEIGHT);

    logic               r_valid;
    logic               n_valid;
    logic [J_X_W-1:0]   r_x;
    logic [J_X_W-1:0]   r_w;
    logic [J_Y_W-1:0]   r_y;
    logic [J_H_W-1:0]   r_h;
    logic [15:0]        r_col;

    logic               accept;
    logic signed [17:0] sx, sy, sw, sh;
    logic signed [17:0] far_x, far_y;
    logic signed [17:0] left, right, top, bottom;
    logic signed [17:0] clip_w, clip_h;
    logic               reject;
    logic [J_IDX_W-1:0] idx;
    logic [J_X_W-1:0]   base;

    assign busy   = r_valid & i_q_full;
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_q_full;

    // Reject test and clip to the canvas, full precision
    always_comb begin
        sx     = 18'(i_req.pos_x);
        sy     = 18'(i_req.pos_y);
        sw     = 18'(i_req.rect_width);
        sh     = 18'(i_req.rect_height);
        far_x  = sx + sw;
        far_y  = sy + sh;
        reject = (sw <= 18'sd0) || (sh <= 18'sd0) || (sx >= TW_S) || (sy >= TH_S)
                 || (far_x <= 18'sd0) || (far_y <= 18'sd0);
        left   = (sx < 18'sd0) ? 18'sd0 : sx;
        top    = (sy < 18'sd0) ? 18'sd0 : sy;
        right  = (far_x > TW_S) ? TW_S : far_x;
        bottom = (far_y > TH_S) ? TH_S : far_y;
        clip_w = right - left;
        clip_h = bottom - top;
    end

    // Stage valid: held while the queue is full
    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = ~reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Clipped rectangle register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= J_X_W'(left);
            r_w   <= J_X_W'(clip_w);
            r_y   <= J_Y_W'(top);
            r_h   <= J_H_W'(clip_h);
            r_col <= i_req.fill_colour;
        end
    end

    // First panel: count panel edges at or left of x
    always_comb begin
        idx  = '0;
        base = '0;
        for (int k = 1; k < PANELS; k++) begin
            if (r_x >= J_X_W'(k * PANEL_WIDTH)) begin
                idx  = J_IDX_W'(k);
                base = J_X_W'(k * PANEL_WIDTH);
            end
        end
    end

    always_comb begin
        o_job.idx    = idx;
        o_job.loc    = J_LOC_W'(r_x - base);
        o_job.width  = r_w;
        o_job.top    = r_y;
        o_job.height = r_h;
        o_job.colour = r_col;
    end

endmodule

[sv/trcs_queue.sv]
// Small show-ahead queue of clipped jobs between front and back.
module trcs_queue import trcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_empty,
    output logic o_full,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push, do_pop;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_slot[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

[sv/trcs_back.sv]
// Back end: cuts a clipped job at panel edges, one part per cycle.
module trcs_back import trcs_pkg::*; #(
    parameter int PANELS      = DEF_PANELS,
    parameter int PANEL_WIDTH = DEF_PANEL_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    input  t_job  i_job,
    output logic  o_pop,
    output logic  o_strobe,
    output t_part o_part
);

    localparam int PART_LIM = (PANELS < MAX_PARTS) ? PANELS : MAX_PARTS;

    logic               r_active;
    logic [J_IDX_W-1:0] r_idx;
    logic [J_LOC_W-1:0] r_loc;
    logic [J_X_W-1:0]   r_rem;
    logic [J_Y_W-1:0]   r_y;
    logic [J_H_W-1:0]   r_h;
    logic [15:0]        r_col;
    logic [CNT_W-1:0]   r_cnt;

    logic [J_X_W-1:0]   avail;
    logic [J_X_W-1:0]   part;
    logic [J_X_W-1:0]   rem_next;
    logic               last;
    logic               load;

    // Current part: what is left or the rest of this panel
    always_comb begin
        avail    = J_X_W'(PANEL_WIDTH) - J_X_W'(r_loc);
        part     = (r_rem < avail) ? r_rem : avail;
        rem_next = r_rem - part;
        last     = (rem_next == '0) || (r_cnt == CNT_W'(PART_LIM - 1));
    end

    assign o_pop = ~i_q_empty & (~r_active | last);
    assign load  = o_pop;

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_active <= ~last;
                r_cnt    <= r_cnt + 1'b1;
            end
        end
    end

    // Job registers: load a new job or step to the next panel
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx <= i_job.idx;
            r_loc <= i_job.loc;
            r_rem <= i_job.width;
            r_y   <= i_job.top;
            r_h   <= i_job.height;
            r_col <= i_job.colour;
        end else if (r_active) begin
            r_idx <= r_idx + 1'b1;
            r_loc <= '0;
            r_rem <= rem_next;
        end
    end

    assign o_strobe = r_active;

    always_comb begin
        o_part.panel       = r_idx[1:0];
        o_part.local_x     = r_loc[7:0];
        o_part.out_y       = r_y[8:0];
        o_part.part_width  = part[7:0];
        o_part.part_height = r_h[8:0];
        o_part.out_colour  = r_col;
        o_part.last_part   = last;
    end

endmodule

[sv/tiled_rect_clip_split.sv]
// Top level of the fill-rectangle clipper and panel splitter.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------
//  request   | start in, busy out    | i_req  (t_req)
//  part      | o_strobe out          | o_part (t_part), one cycle each
//
//  A request is taken when start is high and busy is low. It is clipped and
//  registered, goes through a two-entry queue, and the splitter then gives one
//  part per cycle, so a command gives as many parts as the panels it covers
//  (1 to 4). Rejected requests give nothing. The first part reaches the outputs
//  through the clip register, the queue slot and the splitter's job registers.
//  busy rises only when the queue and the clip stage are both full; the part
//  outputs are never held off. Reset is synchronous and empties every stage.
module tiled_rect_clip_split import trcs_pkg::*; #(
    parameter int PANELS        = DEF_PANELS,
    parameter int PANEL_WIDTH   = DEF_PANEL_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    output logic  o_strobe,
    output t_part o_part
);

    logic q_full, q_empty, push, pop;
    t_job front_job, back_job;

    // Accept, reject and clip
    trcs_front #(
        .PANELS        (PANELS),
        .PANEL_WIDTH   (PANEL_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    // Decoupling queue
    trcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_job   (back_job)
    );

    // Panel split
    trcs_back #(
        .PANELS      (PANELS),
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (back_job),
        .o_pop     (pop),
        .o_strobe  (o_strobe),
        .o_part    (o_part)
    );

endmodule
